// ----- hw/rtl/hsv_to_rgb_converter_assert.svh -----
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset
`define HSVRGB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hsv_to_rgb_converter: assertion failed");

// Condition in one cycle implies a consequence in the next
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("hsv_to_rgb_converter: assertion failed");

`else

`define HSVRGB_ASSERT(label, clk, rst_n, prop)

`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

// ----- hw/rtl/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point format, request payload types and sector codes.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // Fraction bits of the internal unsigned fixed-point format
    localparam int FRAC_BITS = 15;
    // Width of one field on the ports
    localparam int FIELD_W   = 16;
    // Internal value width, holds 0..ONE
    localparam int VAL_W     = FRAC_BITS + 1;
    // Width of hue times six
    localparam int SCALED_W  = VAL_W + 3;
    // Width used to compare a port field against ONE
    localparam int CMP_W     = (FIELD_W > VAL_W) ? FIELD_W : VAL_W;

    localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

    // Hue sector, selects the channel permutation
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        logic [FIELD_W-1:0] hue_in;
        logic [FIELD_W-1:0] sat_in;
        logic [FIELD_W-1:0] val_in;
        logic [FIELD_W-1:0] alpha_in;
    } hsv_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] red_out;
        logic [FIELD_W-1:0] green_out;
        logic [FIELD_W-1:0] blue_out;
        logic [FIELD_W-1:0] alpha_out;
    } rgb_req_t;

    // Saturate a port field to ONE
    function automatic logic [VAL_W-1:0] clamp_one(input logic [FIELD_W-1:0] x);
        logic [CMP_W-1:0] xe;
        xe = CMP_W'(x);
        if (xe > CMP_W'(ONE))
        begin
            return ONE;
        end
        return VAL_W'(xe);
    endfunction

endpackage

// ----- hw/rtl/hsvrgb_fx_mul.sv -----
// ----------------------------------------------------------------------------
// Registered fixed-point multiplier
// Product of two unsigned values, truncated by FRAC_BITS, one register.
// ----------------------------------------------------------------------------
module hsvrgb_fx_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic [hsvrgb_pkg::VAL_W-1:0]  a,
    input  logic [hsvrgb_pkg::VAL_W-1:0]  b,
    output logic [hsvrgb_pkg::VAL_W-1:0]  product
);

    logic [2*hsvrgb_pkg::VAL_W-1:0] full;
    logic [hsvrgb_pkg::VAL_W-1:0]   product_next;
    logic [hsvrgb_pkg::VAL_W-1:0]   product_reg;

    // Full product, then drop the fraction bits (operands stay <= ONE)
    assign full         = a * b;
    assign product_next = hsvrgb_pkg::VAL_W'(full >> hsvrgb_pkg::FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

// ----- hw/rtl/hsv_to_rgb_converter.sv -----
// Throughput: one pixel per cycle while rgb_ready is high; each pipeline stage holds one request.
// Stages: clamp and sector split, three multipliers, two multipliers, permute.
// Each stage advances when the stage after it is empty or advancing.
// Reset clears only the valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Four-stage pipelined HSV to RGB conversion in unsigned fixed point.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  hsv_valid,
    output logic                  hsv_ready,
    input  hsvrgb_pkg::hsv_req_t  hsv_data,
    output logic                  rgb_valid,
    input  logic                  rgb_ready,
    output hsvrgb_pkg::rgb_req_t  rgb_data
);

    localparam int VW = hsvrgb_pkg::VAL_W;
    localparam int FB = hsvrgb_pkg::FRAC_BITS;

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !v4_reg || rgb_ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign v1_next = adv1 ? hsv_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg    : v2_reg;
    assign v3_next = adv3 ? v2_reg    : v3_reg;
    assign v4_next = adv4 ? v3_reg    : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign hsv_ready = adv1;

    // ------------------------------------------------------------------
    // Stage 1: clamp inputs, split hue*6 into sector and fraction
    // ------------------------------------------------------------------
    logic [VW-1:0]             hue_c, sat_c, val_c, alpha_c;
    logic [hsvrgb_pkg::SCALED_W-1:0] scaled;
    hsvrgb_pkg::sector_t       sector_next;
    logic [FB-1:0]             frac_next;

    logic [VW-1:0]             s1_sat_reg, s1_val_reg, s1_alpha_reg;
    logic [VW-1:0]             s1_frac_reg, s1_frac_c_reg, s1_sat_c_reg;
    hsvrgb_pkg::sector_t       s1_sector_reg;
    logic                      s1_gray_reg;

    assign hue_c   = hsvrgb_pkg::clamp_one(hsv_data.hue_in);
    assign sat_c   = hsvrgb_pkg::clamp_one(hsv_data.sat_in);
    assign val_c   = hsvrgb_pkg::clamp_one(hsv_data.val_in);
    assign alpha_c = hsvrgb_pkg::clamp_one(hsv_data.alpha_in);

    // hue * 6 as two shifted adds
    assign scaled = (hsvrgb_pkg::SCALED_W'(hue_c) << 2) + (hsvrgb_pkg::SCALED_W'(hue_c) << 1);

    // Full-circle hue wraps to sector 0 with no fraction
    always_comb
    begin
        if (hue_c == hsvrgb_pkg::ONE)
        begin
            sector_next = hsvrgb_pkg::SEC_RED_YELLOW;
            frac_next   = '0;
        end
        else
        begin
            sector_next = hsvrgb_pkg::sector_t'(scaled[FB+2:FB]);
            frac_next   = scaled[FB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_sat_reg    <= sat_c;
            s1_val_reg    <= val_c;
            s1_alpha_reg  <= alpha_c;
            s1_frac_reg   <= VW'(frac_next);
            s1_frac_c_reg <= hsvrgb_pkg::ONE - VW'(frac_next);
            s1_sat_c_reg  <= hsvrgb_pkg::ONE - sat_c;
            s1_sector_reg <= sector_next;
            s1_gray_reg   <= (sat_c == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: s*f, s*(1-f), p = v*(1-s)
    // ------------------------------------------------------------------
    logic [VW-1:0]       s2_sf, s2_sfc, s2_p;
    logic [VW-1:0]       s2_val_reg, s2_alpha_reg;
    hsvrgb_pkg::sector_t s2_sector_reg;
    logic                s2_gray_reg;

    hsvrgb_fx_mul u_mul_sf (
        .clk     (clk),
        .en      (adv2),
        .a       (s1_sat_reg),
        .b       (s1_frac_reg),
        .product (s2_sf)
    );

    hsvrgb_fx_mul u_mul_sfc (
        .clk     (clk),
        .en      (adv2),
        .a       (s1_sat_reg),
        .b       (s1_frac_c_reg),
        .product (s2_sfc)
    );

    hsvrgb_fx_mul u_mul_p (
        .clk     (clk),
        .en      (adv2),
        .a       (s1_val_reg),
        .b       (s1_sat_c_reg),
        .product (s2_p)
    );

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_val_reg    <= s1_val_reg;
            s2_alpha_reg  <= s1_alpha_reg;
            s2_sector_reg <= s1_sector_reg;
            s2_gray_reg   <= s1_gray_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: q = v*(1 - s*f), t = v*(1 - s*(1-f))
    // ------------------------------------------------------------------
    logic [VW-1:0]       s3_q, s3_t;
    logic [VW-1:0]       s3_p_reg, s3_val_reg, s3_alpha_reg;
    hsvrgb_pkg::sector_t s3_sector_reg;
    logic                s3_gray_reg;

    hsvrgb_fx_mul u_mul_q (
        .clk     (clk),
        .en      (adv3),
        .a       (s2_val_reg),
        .b       (hsvrgb_pkg::ONE - s2_sf),
        .product (s3_q)
    );

    hsvrgb_fx_mul u_mul_t (
        .clk     (clk),
        .en      (adv3),
        .a       (s2_val_reg),
        .b       (hsvrgb_pkg::ONE - s2_sfc),
        .product (s3_t)
    );

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_p_reg      <= s2_p;
            s3_val_reg    <= s2_val_reg;
            s3_alpha_reg  <= s2_alpha_reg;
            s3_sector_reg <= s2_sector_reg;
            s3_gray_reg   <= s2_gray_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sector permutation into the output register
    // ------------------------------------------------------------------
    logic [VW-1:0]        red_c, green_c, blue_c;
    hsvrgb_pkg::rgb_req_t rgb_next;
    hsvrgb_pkg::rgb_req_t rgb_reg;

    always_comb
    begin
        red_c   = s3_val_reg;
        green_c = s3_val_reg;
        blue_c  = s3_val_reg;
        if (!s3_gray_reg)
        begin
            case (s3_sector_reg)
                hsvrgb_pkg::SEC_RED_YELLOW:
                begin
                    red_c = s3_val_reg; green_c = s3_t;       blue_c = s3_p_reg;
                end
                hsvrgb_pkg::SEC_YELLOW_GREEN:
                begin
                    red_c = s3_q;       green_c = s3_val_reg; blue_c = s3_p_reg;
                end
                hsvrgb_pkg::SEC_GREEN_CYAN:
                begin
                    red_c = s3_p_reg;   green_c = s3_val_reg; blue_c = s3_t;
                end
                hsvrgb_pkg::SEC_CYAN_BLUE:
                begin
                    red_c = s3_p_reg;   green_c = s3_q;       blue_c = s3_val_reg;
                end
                hsvrgb_pkg::SEC_BLUE_MAGENTA:
                begin
                    red_c = s3_t;       green_c = s3_p_reg;   blue_c = s3_val_reg;
                end
                default:
                begin
                    red_c = s3_val_reg; green_c = s3_p_reg;   blue_c = s3_q;
                end
            endcase
        end
    end

    assign rgb_next.red_out   = hsvrgb_pkg::FIELD_W'(red_c);
    assign rgb_next.green_out = hsvrgb_pkg::FIELD_W'(green_c);
    assign rgb_next.blue_out  = hsvrgb_pkg::FIELD_W'(blue_c);
    assign rgb_next.alpha_out = hsvrgb_pkg::FIELD_W'(s3_alpha_reg);

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = v4_reg;
    assign rgb_data  = rgb_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted request always lands in stage 1
    `HSVRGB_ASSERT_NEXT(a_accept_lands, clk, rst_n, hsv_valid && hsv_ready, v1_reg)
    // Sector never exceeds the last permutation
    `HSVRGB_ASSERT(a_sector_range, clk, rst_n, !v1_reg || (s1_sector_reg <= hsvrgb_pkg::SEC_MAGENTA_RED))
    // p never exceeds the value it scales
    `HSVRGB_ASSERT(a_p_below_val, clk, rst_n, !v2_reg || (s2_p <= s2_val_reg))
    // A stalled stage 3 request is not dropped
    `HSVRGB_ASSERT_NEXT(a_stage3_held, clk, rst_n, v3_reg && !adv4, v3_reg)

endmodule
